@@ hdl/psgt_pkg.sv @@
`default_nettype none
package psgt_pkg;
  localparam int SLOT_COUNT = 256;
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int ST_W = 40 + 32 + 8;

  typedef enum logic [2:0] {
    CFG_EMA_WEIGHT   = 3'd0,
    CFG_ALERT_LEVEL  = 3'd1,
    CFG_RUN_LIMIT    = 3'd2,
    CFG_SMALL_BASE   = 3'd3,
    CFG_TREND_BAND   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_DIV,
    ST_FIN,
    ST_SCORE,
    ST_OUT
  } state_t;

  localparam logic REQ_SEED = 1'b0;
  localparam logic [1:0] DIR_STABLE = 2'd0;
  localparam logic [1:0] DIR_GROW   = 2'd1;
  localparam logic [1:0] DIR_SHRINK = 2'd2;
endpackage
`default_nettype wire

@@ hdl/psgt_ram.sv @@
`default_nettype none
module psgt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hdl/per_slot_growth_trend_tracker.sv @@
// per-slot growth trend tracker
// input: start/busy command channel, item taken when start is high and busy low
// carrying in_req_type (seed or update), in_slot_index and in_sample_count
// result: one per item, shown for exactly one cycle with out_valid high;
// the receiver cannot stall, so the result is simply presented and dropped
// configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
// register, cfg_data carries the value; ready is always high and writes are
// only expected while busy is low
// sequence: read, calc, then for a percentage growth a bit-serial divider that
// gives one quotient bit per cycle, then the shift-and-add divide by ten of the
// rank score, then the result; a seed or an absolute-growth update skips the
// divider
// busy stays high from acceptance until the result cycle, so the next item
// is taken only after the previous result has been shown
// slot state (average, previous count, rise run) lives in one synchronous
// ram with a registered read, read, modified and written back per item
// reset clears control state and restores register defaults; slot state is
// undefined until a slot is seeded
`default_nettype none
module per_slot_growth_trend_tracker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_slot_index,
  input  wire logic [31:0] in_sample_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [19:0] cfg_data,
  output logic             out_valid,
  output logic [7:0]       out_slot_echo,
  output logic [39:0]      out_average_q8,
  output logic signed [39:0] out_growth_hundredths,
  output logic [7:0]       out_rise_run,
  output logic             out_growth_alert,
  output logic             out_leak_warning,
  output logic [1:0]       out_trend_dir,
  output logic [44:0]      out_rank_score_q8
);
  psgt_pkg::state_t state_r, state_nxt;

  logic [8:0]  ema_weight_r;
  logic [19:0] alert_level_r;
  logic [7:0]  run_limit_r;
  logic [15:0] small_base_r;
  logic [19:0] trend_band_r;

  logic        req_r;
  logic [7:0]  slot_r;
  logic [31:0] sample_r;
  logic [39:0] avg_r;
  logic [7:0]  run_r;
  logic signed [39:0] growth_r;
  logic [45:0] rem_r;
  logic [45:0] quo_r;
  logic [45:0] num_r;
  logic [31:0] div_r;
  logic        neg_r;
  logic [5:0]  cnt_r;
  logic        use_div_r;
  logic [44:0] score_r;
  logic [48:0] prod_r;
  logic [48:0] dq_r;

  logic [psgt_pkg::ST_W-1:0] rd_data, wr_data;
  logic we;

  assign cfg_ready = 1'b1;
  assign busy = (state_r != psgt_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ema_weight_r  <= 9'd77;
      alert_level_r <= 20'd500;
      run_limit_r   <= 8'd3;
      small_base_r  <= 16'd10;
      trend_band_r  <= 20'd100;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        psgt_pkg::CFG_EMA_WEIGHT:  ema_weight_r  <= cfg_data[8:0];
        psgt_pkg::CFG_ALERT_LEVEL: alert_level_r <= cfg_data;
        psgt_pkg::CFG_RUN_LIMIT:   run_limit_r   <= cfg_data[7:0];
        psgt_pkg::CFG_SMALL_BASE:  small_base_r  <= cfg_data[15:0];
        psgt_pkg::CFG_TREND_BAND:  trend_band_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  psgt_ram #(.WIDTH(psgt_pkg::ST_W), .DEPTH(psgt_pkg::SLOT_COUNT)) u_state_ram (
    .clk   (clk),
    .we    (we),
    .waddr (slot_r[psgt_pkg::SLOT_W-1:0]),
    .wdata (wr_data),
    .raddr (slot_r[psgt_pkg::SLOT_W-1:0]),
    .rdata (rd_data)
  );

  logic [39:0] st_avg;
  logic [31:0] st_prev;
  logic [7:0]  st_run;
  assign st_avg  = rd_data[79:40];
  assign st_prev = rd_data[39:8];
  assign st_run  = rd_data[7:0];

  // datapath for calc step
  logic [8:0]  w_eff;
  logic [49:0] blend;
  logic [39:0] avg_calc;
  logic [7:0]  run_calc;
  logic [31:0] mag;
  logic        neg_calc;
  logic [45:0] mag100;
  logic [45:0] mag10000;
  always_comb begin
    w_eff = (ema_weight_r > 9'd256) ? 9'd256 : ema_weight_r;
    blend = 50'(w_eff) * 50'({sample_r, 8'd0}) + 50'(9'd256 - w_eff) * 50'(st_avg)
            + 50'd128;
    avg_calc = blend[47:8];
    run_calc = (sample_r > st_prev) ? ((st_run == 8'hff) ? st_run : st_run + 8'd1) : 8'd0;
    neg_calc = (sample_r < st_prev);
    mag = neg_calc ? (st_prev - sample_r) : (sample_r - st_prev);
    mag100 = 46'(mag) * 46'd100;
    mag10000 = 46'(mag) * 46'd10000;
  end

  // one restoring step
  logic [46:0] trial;
  assign trial = {rem_r, num_r[45]} - {15'd0, div_r};

  logic signed [40:0] growth_s;
  logic signed [20:0] band_s;
  logic [48:0] prod;
  assign band_s = $signed({1'b0, trend_band_r});
  assign growth_s = 41'(growth_r);
  assign prod = 49'(avg_r) * 49'(10 + run_r);

  // divide by ten: shift-and-add estimate, low by at most one, then fixed up
  logic [45:0] q10;
  logic [48:0] r10;
  assign q10 = dq_r[48:3];
  assign r10 = prod_r - ({q10, 3'd0} + {2'd0, q10, 1'b0});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psgt_pkg::ST_IDLE:  if (start) state_nxt = psgt_pkg::ST_READ;
      psgt_pkg::ST_READ:  state_nxt = psgt_pkg::ST_CALC;
      psgt_pkg::ST_CALC:
        state_nxt = (req_r != psgt_pkg::REQ_SEED && st_prev > 32'(small_base_r))
                    ? psgt_pkg::ST_DIV : psgt_pkg::ST_FIN;
      psgt_pkg::ST_DIV:   if (cnt_r == 6'd45) state_nxt = psgt_pkg::ST_FIN;
      psgt_pkg::ST_FIN:   state_nxt = psgt_pkg::ST_SCORE;
      psgt_pkg::ST_SCORE: if (cnt_r == 6'd5) state_nxt = psgt_pkg::ST_OUT;
      psgt_pkg::ST_OUT:   state_nxt = psgt_pkg::ST_IDLE;
      default:            state_nxt = psgt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    we = (state_r == psgt_pkg::ST_CALC);
    wr_data = (req_r == psgt_pkg::REQ_SEED) ? {sample_r, 8'd0, sample_r, 8'd0}
                                           : {avg_calc, sample_r, run_calc};
    out_valid = (state_r == psgt_pkg::ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= psgt_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      psgt_pkg::ST_IDLE: if (start) begin
        req_r <= in_req_type;
        slot_r <= in_slot_index;
        sample_r <= in_sample_count;
      end
      psgt_pkg::ST_CALC: begin
        cnt_r <= 6'd0;
        rem_r <= 46'd0;
        quo_r <= 46'd0;
        div_r <= st_prev;
        neg_r <= neg_calc;
        if (req_r == psgt_pkg::REQ_SEED) begin
          avg_r <= {sample_r, 8'd0};
          run_r <= 8'd0;
          use_div_r <= 1'b0;
          num_r <= 46'd0;
        end else begin
          avg_r <= avg_calc;
          run_r <= run_calc;
          use_div_r <= (st_prev > 32'(small_base_r));
          num_r <= (st_prev > 32'(small_base_r)) ? mag10000 : mag100;
        end
      end
      psgt_pkg::ST_DIV: begin
        cnt_r <= cnt_r + 6'd1;
        num_r <= {num_r[44:0], 1'b0};
        if (!trial[46]) begin
          rem_r <= trial[45:0];
          quo_r <= {quo_r[44:0], 1'b1};
        end else begin
          rem_r <= {rem_r[44:0], num_r[45]};
          quo_r <= {quo_r[44:0], 1'b0};
        end
      end
      psgt_pkg::ST_FIN: begin
        cnt_r <= 6'd0;
        prod_r <= prod;
        if (use_div_r ? (quo_r > 46'h7F_FFFF_FFFF) : (num_r > 46'h7F_FFFF_FFFF))
          growth_r <= neg_r ? 40'sh80_0000_0000 : 40'sh7F_FFFF_FFFF;
        else if (neg_r)
          growth_r <= -$signed(use_div_r ? quo_r[39:0] : num_r[39:0]);
        else
          growth_r <= use_div_r ? quo_r[39:0] : num_r[39:0];
      end
      psgt_pkg::ST_SCORE: begin
        cnt_r <= cnt_r + 6'd1;
        case (cnt_r)
          6'd0: dq_r <= {1'b0, prod_r[48:1]} + {2'b0, prod_r[48:2]};
          6'd1: dq_r <= dq_r + (dq_r >> 4);
          6'd2: dq_r <= dq_r + (dq_r >> 8);
          6'd3: dq_r <= dq_r + (dq_r >> 16);
          6'd4: dq_r <= dq_r + (dq_r >> 32);
          default: score_r <= 45'(q10 + ((r10 > 49'd9) ? 46'd1 : 46'd0));
        endcase
      end
      default: ;
    endcase
  end

  assign out_slot_echo = slot_r;
  assign out_average_q8 = avg_r;
  assign out_growth_hundredths = growth_r;
  assign out_rise_run = run_r;
  assign out_growth_alert = growth_s > $signed({21'd0, alert_level_r});
  assign out_leak_warning = run_r >= run_limit_r;
  assign out_trend_dir = (growth_s > 41'(band_s)) ? psgt_pkg::DIR_GROW :
                         (growth_s < -41'(band_s)) ? psgt_pkg::DIR_SHRINK :
                         psgt_pkg::DIR_STABLE;
  assign out_rank_score_q8 = score_r;

`ifndef ASSERT_OFF
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside busy");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result repeated");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("item not taken");
`endif
endmodule
`default_nettype wire

@@ tb/sv/tb_per_slot_growth_trend_tracker.sv @@
`timescale 1ns / 1ps
module tb_per_slot_growth_trend_tracker;

  typedef struct packed {
    logic        req;
    logic [7:0]  slot;
    logic [31:0] sample;
  } sample_req_t;

  typedef struct packed {
    logic [7:0]         slot;
    logic [39:0]        avg;
    logic signed [39:0] growth;
    logic [7:0]         run;
    logic               alert;
    logic               leak;
    logic [1:0]         dir;
    logic [44:0]        score;
  } trend_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_req_type = 1'b0;
  logic [7:0] in_slot_index = '0;
  logic [31:0] in_sample_count = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [19:0] cfg_data = '0;
  logic out_valid;
  logic [7:0] out_slot_echo;
  logic [39:0] out_average_q8;
  logic signed [39:0] out_growth_hundredths;
  logic [7:0] out_rise_run;
  logic out_growth_alert;
  logic out_leak_warning;
  logic [1:0] out_trend_dir;
  logic [44:0] out_rank_score_q8;

  per_slot_growth_trend_tracker u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [8:0]  weight_r = 9'd77;
  logic [19:0] alert_r = 20'd500;
  logic [7:0]  run_limit_r = 8'd3;
  logic [15:0] small_base_r = 16'd10;
  logic [19:0] band_r = 20'd100;
  logic [39:0] avg_mem [256];
  logic [31:0] prev_mem [256];
  logic [7:0]  run_mem [256];
  bit          seeded [256];

  sample_req_t pending_q[$];
  trend_res_t  expected_q[$];
  int send_idle_pct = 0;
  int mismatches = 0;
  bit feed_done = 1'b0;

  function automatic trend_res_t predict_trend(sample_req_t r);
    trend_res_t e;
    longint signed diff, g, band, lim;
    logic [63:0] w, a;
    logic [7:0] run;
    logic [31:0] prev;
    lim = 64'sd549755813887;
    g = 0;
    if (r.req == psgt_pkg::REQ_SEED) begin
      a = {r.sample, 8'd0};
      run = 8'd0;
    end else begin
      w = (weight_r > 256) ? 64'd256 : 64'(weight_r);
      prev = prev_mem[r.slot];
      a = (w * {r.sample, 8'd0} + (256 - w) * avg_mem[r.slot] + 128) >> 8;
      a &= 64'hFF_FFFF_FFFF;
      diff = longint'(r.sample) - longint'(prev);
      if (prev > small_base_r && prev != 0) g = (diff * 10000) / longint'(prev);
      else g = diff * 100;
      if (g > lim) g = lim;
      if (g < -lim - 1) g = -lim - 1;
      run = run_mem[r.slot];
      if (r.sample > prev) begin
        if (run != 8'hFF) run++;
      end else begin
        run = 8'd0;
      end
    end
    avg_mem[r.slot] = a[39:0];
    prev_mem[r.slot] = r.sample;
    run_mem[r.slot] = run;
    band = longint'(band_r);
    e.slot = r.slot;
    e.avg = a[39:0];
    e.growth = g[39:0];
    e.run = run;
    e.alert = g > longint'(alert_r);
    e.leak = run >= run_limit_r;
    e.dir = (g > band) ? psgt_pkg::DIR_GROW :
            (g < -band) ? psgt_pkg::DIR_SHRINK : psgt_pkg::DIR_STABLE;
    e.score = 45'((a * (10 + run)) / 10);
    return e;
  endfunction

  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      expected_q.push_back(predict_trend('{in_req_type, in_slot_index, in_sample_count}));
      void'(pending_q.pop_front());
    end
    if (rst_n && (!start || !busy)) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        sample_req_t nx;
        nx = pending_q[0];
        start <= 1'b1;
        in_req_type <= nx.req;
        in_slot_index <= nx.slot;
        in_sample_count <= nx.sample;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      trend_res_t got, e;
      got = '{out_slot_echo, out_average_q8, out_growth_hundredths, out_rise_run,
              out_growth_alert, out_leak_warning, out_trend_dir, out_rank_score_q8};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        e = expected_q.pop_front();
        if (got !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("expected %p actual %p", e, got);
        end
      end
    end
  end

  task automatic write_reg(psgt_pkg::cfg_idx_t idx, logic [19:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      psgt_pkg::CFG_EMA_WEIGHT:  weight_r = v[8:0];
      psgt_pkg::CFG_ALERT_LEVEL: alert_r = v;
      psgt_pkg::CFG_RUN_LIMIT:   run_limit_r = v[7:0];
      psgt_pkg::CFG_SMALL_BASE:  small_base_r = v[15:0];
      psgt_pkg::CFG_TREND_BAND:  band_r = v;
      default: ;
    endcase
  endtask

  task automatic queue_item(logic req, logic [7:0] slot, logic [31:0] v);
    if (req != psgt_pkg::REQ_SEED && !seeded[slot]) req = psgt_pkg::REQ_SEED;
    seeded[slot] = 1'b1;
    pending_q.push_back('{req, slot, v});
  endtask

  task automatic drain;
    while (pending_q.size() != 0 || start || busy || expected_q.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_count();
    case ($urandom_range(4))
      0: return $urandom_range(20);
      1: return $urandom;
      2: return 32'hFFFF_FFFF - $urandom_range(3);
      default: return $urandom_range(5000);
    endcase
  endfunction

  task automatic random_phase(int n, int idle);
    logic [7:0] s;
    logic [31:0] v;
    send_idle_pct = idle;
    for (int i = 0; i < n; i++) begin
      s = 8'($urandom_range(15));
      if ($urandom_range(9) == 0) s = 8'($urandom);
      if (!seeded[s] || $urandom_range(19) == 0) queue_item(psgt_pkg::REQ_SEED, s, rand_count());
      else begin
        // mostly rising runs to reach the leak warning
        v = ($urandom_range(3) != 0 && prev_mem[s] < 32'hFFFF_0000) ?
            prev_mem[s] + $urandom_range(1, 40000) : rand_count();
        queue_item(1'b1, s, v);
      end
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: seeds, absolute and percent growth, rise run
    queue_item(psgt_pkg::REQ_SEED, 8'd0, 32'd0);
    queue_item(1'b1, 8'd0, 32'hFFFF_FFFF);
    queue_item(1'b1, 8'd0, 32'd0);
    queue_item(psgt_pkg::REQ_SEED, 8'd255, 32'hFFFF_FFFF);
    queue_item(1'b1, 8'd255, 32'd0);
    queue_item(psgt_pkg::REQ_SEED, 8'd1, 32'd1);
    queue_item(1'b1, 8'd1, 32'hFFFF_FFFF);
    queue_item(psgt_pkg::REQ_SEED, 8'd2, 32'd100);
    for (int i = 1; i <= 6; i++) queue_item(1'b1, 8'd2, 32'd100 + 32'(i * 10));
    queue_item(1'b1, 8'd2, 32'd100);
    queue_item(1'b1, 8'd2, 32'd100);
    queue_item(psgt_pkg::REQ_SEED, 8'hAA, 32'h5555_5555);
    queue_item(1'b1, 8'hAA, 32'hAAAA_AAAA);
    queue_item(psgt_pkg::REQ_SEED, 8'h55, 32'd10);
    queue_item(1'b1, 8'h55, 32'd11);
    drain();
    write_reg(psgt_pkg::CFG_EMA_WEIGHT, 20'd256);
    write_reg(psgt_pkg::CFG_ALERT_LEVEL, 20'd0);
    write_reg(psgt_pkg::CFG_RUN_LIMIT, 20'd1);
    write_reg(psgt_pkg::CFG_SMALL_BASE, 20'd0);
    write_reg(psgt_pkg::CFG_TREND_BAND, 20'd0);
    random_phase(130, 26);
    write_reg(psgt_pkg::CFG_EMA_WEIGHT, 20'd511);
    write_reg(psgt_pkg::CFG_ALERT_LEVEL, 20'd1000000);
    write_reg(psgt_pkg::CFG_RUN_LIMIT, 20'd255);
    write_reg(psgt_pkg::CFG_SMALL_BASE, 20'd65535);
    write_reg(psgt_pkg::CFG_TREND_BAND, 20'hFFFFF);
    random_phase(130, 86);
    write_reg(psgt_pkg::CFG_EMA_WEIGHT, 20'd0);
    write_reg(psgt_pkg::CFG_RUN_LIMIT, 20'd0);
    write_reg(psgt_pkg::CFG_SMALL_BASE, 20'd300);
    write_reg(psgt_pkg::CFG_TREND_BAND, 20'd1000000);
    write_reg(psgt_pkg::CFG_ALERT_LEVEL, 20'd250);
    random_phase(70, 0);
    write_reg(psgt_pkg::CFG_EMA_WEIGHT, 20'd1);
    write_reg(psgt_pkg::CFG_RUN_LIMIT, 20'd2);
    write_reg(psgt_pkg::CFG_SMALL_BASE, 20'd20);
    random_phase(70, 0);
    feed_done = 1'b1;
  end

  always @(posedge clk) begin
    if (feed_done) begin
      if (mismatches == 0) begin
        $display("per_slot_growth_trend_tracker: match");
      end else begin
        $display("per_slot_growth_trend_tracker: mismatch");
      end
      $finish;
    end
  end

  initial begin
    #400000;
    $display("per_slot_growth_trend_tracker: mismatch");
    $finish;
  end
endmodule
